[rtl/mipbox_pkg.sv]
// Package for the mipmap box downsampler: constants, types and state codes.
package mipbox_pkg;

    localparam int MaxDim      = 4096;
    localparam int MaxLevels   = 13;
    localparam int MaxChannels = 4;
    localparam int DimW        = 13;
    localparam int CoordW      = 12;
    localparam int LevelW      = 4;
    localparam int AddrW       = 12;
    localparam int SumW        = 9;

    localparam logic [1:0] RegWidth    = 2'd0;
    localparam logic [1:0] RegHeight   = 2'd1;
    localparam logic [1:0] RegChannels = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_WAIT,
        ST_READ,
        ST_COMB
    } t_state;

    typedef logic [MaxChannels-1:0][7:0]     t_pix;
    typedef logic [MaxChannels-1:0][SumW:0]  t_sum;

endpackage

[rtl/mipbox_line_ram.sv]
// Line memory holding the even-row horizontal pair sums of every level.
module mipbox_line_ram (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [mipbox_pkg::AddrW-1:0]               i_waddr,
    input  logic [mipbox_pkg::MaxChannels*mipbox_pkg::SumW-1:0] i_wdata,
    input  logic [mipbox_pkg::AddrW-1:0]               i_raddr,
    output logic [mipbox_pkg::MaxChannels*mipbox_pkg::SumW-1:0] o_rdata
);

    logic [mipbox_pkg::MaxChannels*mipbox_pkg::SumW-1:0] r_mem [mipbox_pkg::MaxDim];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/mipmap_chain_box_downsampler_top.sv]
// Top level of the streaming mipmap generator with a 2x2 box filter.
// Each base pixel is emitted as level 0 and then walked down the level chain by one
// shared sequencer. The pixel is taken in the idle state, and every produced result
// then has the output register loaded in the emit state and is presented in the wait state.
// A level that combines with the stored upper row also passes through the read state,
// for the line-memory read, and the combine state. An output stall holds the sequencer
// in the wait state. The block takes no new pixel until the last result of the current
// one has been accepted.
module mipmap_chain_box_downsampler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_chan0,
    input  logic [7:0]  i_in_chan1,
    input  logic [7:0]  i_in_chan2,
    input  logic [7:0]  i_in_chan3,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_mip_level,
    output logic [11:0] o_pixel_col,
    output logic [11:0] o_pixel_row,
    output logic [7:0]  o_out_chan0,
    output logic [7:0]  o_out_chan1,
    output logic [7:0]  o_out_chan2,
    output logic [7:0]  o_out_chan3,
    output logic        o_run_end,
    output logic        o_image_end
);

    localparam int LW = mipbox_pkg::LevelW;
    localparam int CW = mipbox_pkg::CoordW;
    localparam int DW = mipbox_pkg::DimW;
    localparam int NL = mipbox_pkg::MaxLevels;
    localparam int NC = mipbox_pkg::MaxChannels;
    localparam int AW = mipbox_pkg::AddrW;
    localparam int SW = mipbox_pkg::SumW;

    // configuration
    logic [DW-1:0] r_width, r_height;
    logic [2:0]    r_chans;

    // per-level state
    logic [CW-1:0]         r_col [NL];
    logic [CW-1:0]         r_row [NL];
    mipbox_pkg::t_pix      r_hold [NL];

    // sequencer state
    mipbox_pkg::t_state    r_state, n_state;
    logic [LW-1:0]         r_lvl;
    mipbox_pkg::t_pix      r_cur;
    logic [DW-1:0]         r_pw, r_ph;     // current level dims
    logic [AW:0]           r_off;
    logic                  r_last;
    mipbox_pkg::t_sum      r_pair;
    logic [AW-1:0]         r_idx;          // line-memory address of the combine
    logic [LW-1:0]         r_levels;

    // clamp dims and channel count
    logic [DW-1:0] w_c, h_c, m_c;
    logic [2:0]    cc;
    always_comb begin
        w_c = (r_width == '0) ? DW'(1) : ((r_width > DW'(mipbox_pkg::MaxDim)) ?
              DW'(mipbox_pkg::MaxDim) : r_width);
        h_c = (r_height == '0) ? DW'(1) : ((r_height > DW'(mipbox_pkg::MaxDim)) ?
              DW'(mipbox_pkg::MaxDim) : r_height);
        m_c = (w_c > h_c) ? w_c : h_c;
        cc  = (r_chans == 3'd0) ? 3'd1 : ((r_chans > 3'(NC)) ? 3'(NC) : r_chans);
    end

    // level count: position of the top set bit plus one
    logic [LW-1:0] lv_c;
    always_comb begin
        lv_c = LW'(1);
        for (int b = 1; b < DW; b++) begin
            if (m_c[b]) lv_c = LW'(b + 1);
        end
        if (lv_c > LW'(NL)) lv_c = LW'(NL);
    end

    // current level quantities
    logic [CW-1:0] c_cur, r_cur_row;
    logic [DW-1:0] pw2, ph2, nc_w, nc_h;
    logic [CW:0]   col_inc, row_inc;
    logic          deeper;
    assign c_cur     = r_col[r_lvl];
    assign r_cur_row = r_row[r_lvl];
    assign pw2       = (r_pw > DW'(1)) ? (r_pw >> 1) : DW'(1);
    assign ph2       = (r_ph > DW'(1)) ? (r_ph >> 1) : DW'(1);
    assign col_inc   = {1'b0, c_cur} + 1'b1;
    assign row_inc   = {1'b0, r_cur_row} + 1'b1;
    assign deeper    = (r_lvl + LW'(1)) < r_levels;
    assign nc_w      = pw2;
    assign nc_h      = ph2;

    // horizontal pair for this level
    mipbox_pkg::t_sum pr;
    logic             h_go, h_store, v_pass, v_store, v_comb;
    logic [AW-1:0]    idx;
    always_comb begin
        h_go    = 1'b0;
        h_store = 1'b0;
        for (int ch = 0; ch < NC; ch++) begin
            if (r_pw == DW'(1)) pr[ch] = {1'b0, r_cur[ch], 1'b0};
            else pr[ch] = {2'b00, r_hold[r_lvl][ch]} + {2'b00, r_cur[ch]};
        end
        if (deeper) begin
            if (r_pw == DW'(1)) h_go = 1'b1;
            else if ({1'b0, c_cur} < {pw2[DW-2:0], 1'b0}) begin
                if (!c_cur[0]) h_store = 1'b1;
                else h_go = 1'b1;
            end
        end
        idx = (r_pw == DW'(1)) ? r_off[AW-1:0] : AW'(r_off + (AW+1)'(c_cur >> 1));
        v_pass  = h_go && (r_ph == DW'(1));
        v_store = h_go && (r_ph != DW'(1)) &&
                  ({1'b0, r_cur_row} < {ph2[DW-2:0], 1'b0}) && !r_cur_row[0];
        v_comb  = h_go && (r_ph != DW'(1)) &&
                  ({1'b0, r_cur_row} < {ph2[DW-2:0], 1'b0}) && r_cur_row[0];
    end

    // line memory
    logic [NC*SW-1:0] wdata, rdata;
    logic             mem_we;
    always_comb begin
        for (int ch = 0; ch < NC; ch++) wdata[ch*SW +: SW] = pr[ch][SW-1:0];
    end
    assign mem_we = (r_state == mipbox_pkg::ST_WAIT) && v_store;

    mipbox_line_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (idx),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    // next pixel from pair and stored sum
    mipbox_pkg::t_pix nxt_pass, nxt_comb;
    always_comb begin
        for (int ch = 0; ch < NC; ch++) begin
            nxt_pass[ch] = pr[ch][SW-1:1];
            nxt_comb[ch] = 8'(({1'b0, rdata[ch*SW +: SW]} + r_pair[ch]) >> 2);
        end
    end

    logic end_run;
    assign end_run = !(v_pass || v_comb);

    // input pixel with unused channels zeroed
    mipbox_pkg::t_pix inpix;
    always_comb begin
        inpix[0] = i_in_chan0;
        inpix[1] = (cc > 3'd1) ? i_in_chan1 : 8'd0;
        inpix[2] = (cc > 3'd2) ? i_in_chan2 : 8'd0;
        inpix[3] = (cc > 3'd3) ? i_in_chan3 : 8'd0;
    end

    logic accept, out_take;
    assign accept   = i_valid && !o_stall;
    assign out_take = o_valid && !i_stall;
    assign o_stall  = (r_state != mipbox_pkg::ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mipbox_pkg::ST_IDLE: if (accept) n_state = mipbox_pkg::ST_EMIT;
            mipbox_pkg::ST_EMIT: n_state = mipbox_pkg::ST_WAIT;
            mipbox_pkg::ST_WAIT: begin
                if (out_take) begin
                    if (end_run) n_state = mipbox_pkg::ST_IDLE;
                    else if (v_pass) n_state = mipbox_pkg::ST_EMIT;
                    else n_state = mipbox_pkg::ST_READ;
                end
            end
            mipbox_pkg::ST_READ: n_state = mipbox_pkg::ST_COMB;
            mipbox_pkg::ST_COMB: n_state = mipbox_pkg::ST_EMIT;
            default:             n_state = mipbox_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mipbox_pkg::ST_IDLE;
            r_width  <= DW'(1);
            r_height <= DW'(1);
            r_chans  <= 3'd4;
            o_valid  <= 1'b0;
            for (int l = 0; l < NL; l++) begin
                r_col[l]  <= '0;
                r_row[l]  <= '0;
                r_hold[l] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mipbox_pkg::RegWidth:    r_width  <= i_cfg_data;
                    mipbox_pkg::RegHeight:   r_height <= i_cfg_data;
                    mipbox_pkg::RegChannels: r_chans  <= i_cfg_data[2:0];
                    default: ;
                endcase
                for (int l = 0; l < NL; l++) begin
                    r_col[l] <= '0;
                    r_row[l] <= '0;
                end
            end
            if (r_state == mipbox_pkg::ST_EMIT) o_valid <= 1'b1;
            else if (out_take) o_valid <= 1'b0;
            // advance the level counters once the result leaves
            if (r_state == mipbox_pkg::ST_WAIT && out_take) begin
                if (col_inc >= (CW+1)'(r_pw)) begin
                    r_col[r_lvl] <= '0;
                    r_row[r_lvl] <= (row_inc >= (CW+1)'(r_ph)) ? '0 : row_inc[CW-1:0];
                end else begin
                    r_col[r_lvl] <= col_inc[CW-1:0];
                end
                if (h_store) r_hold[r_lvl] <= r_cur;
                if (end_run && r_last) begin
                    for (int l = 0; l < NL; l++) begin
                        r_col[l] <= '0;
                        r_row[l] <= '0;
                    end
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            mipbox_pkg::ST_IDLE: begin
                r_lvl    <= '0;
                r_cur    <= inpix;
                r_pw     <= w_c;
                r_ph     <= h_c;
                r_off    <= '0;
                r_levels <= lv_c;
                r_last   <= ({1'b0, r_col[0]} == w_c - DW'(1)) &&
                            ({1'b0, r_row[0]} == h_c - DW'(1));
            end
            mipbox_pkg::ST_EMIT: begin
                o_mip_level <= r_lvl;
                o_pixel_col <= c_cur;
                o_pixel_row <= r_cur_row;
                o_out_chan0 <= r_cur[0];
                o_out_chan1 <= r_cur[1];
                o_out_chan2 <= r_cur[2];
                o_out_chan3 <= r_cur[3];
                o_run_end   <= end_run;
                o_image_end <= end_run && r_last;
            end
            mipbox_pkg::ST_WAIT: begin
                r_pair <= pr;
                r_idx  <= idx;
                if (out_take && v_pass) begin
                    r_cur <= nxt_pass;
                    r_lvl <= r_lvl + LW'(1);
                    r_pw  <= nc_w;
                    r_ph  <= nc_h;
                    r_off <= r_off + (AW+1)'(nc_w);
                end
            end
            mipbox_pkg::ST_COMB: begin
                r_cur <= nxt_comb;
                r_lvl <= r_lvl + LW'(1);
                r_pw  <= nc_w;
                r_ph  <= nc_h;
                r_off <= r_off + (AW+1)'(nc_w);
            end
            default: ;
        endcase
    end

    // assertions
    a_one_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_stall || r_state == mipbox_pkg::ST_EMIT)
        else $error("pixel accepted while busy");
    a_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_mip_level < LW'(NL))
        else $error("level out of range");
    a_img_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_image_end |-> o_run_end)
        else $error("image end without run end");

endmodule
